// ===== src/pfwf_pkg.sv =====
// shared types, constants and helpers for the palette white fade sequencer
package pfwf_pkg;

	localparam int PALETTE_ENTRIES = 64;
	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int HIT_W = 9;

	localparam logic [7:0] WHITE_LEVEL       = 8'd224;
	localparam logic [7:0] FADE_STEP         = 8'd32;
	localparam logic [3:0] TICKS_PER_CHANNEL = 4'd8;
	localparam logic [1:0] CHANNEL_COUNT     = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_IN   = 2'd1;
	localparam logic [1:0] MODE_OUT  = 2'd2;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_FADE_OUT  = 3'd1,
		CMD_WHITEN    = 3'd2,
		CMD_FADE_IN   = 3'd3,
		CMD_WRITE     = 3'd4,
		CMD_READ      = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FADE_OUT,
		OP_FADE_IN,
		OP_WHITEN,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [23:0] pal;
		logic [23:0] saved;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  chan;
		logic [7:0]  mask;
		logic        hit;
		logic [23:0] wdata;
	} head_ctl_t;

	// channel 0 red, 1 green, 2 blue
	function automatic logic [7:0] get_chan(input logic [23:0] rgb, input logic [1:0] ch);
		logic [7:0] v;
		case (ch)
			2'd0:    v = rgb[23:16];
			2'd1:    v = rgb[15:8];
			2'd2:    v = rgb[7:0];
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [23:0] set_chan(input logic [23:0] rgb, input logic [1:0] ch,
			input logic [7:0] v);
		logic [23:0] r;
		r = rgb;
		case (ch)
			2'd0:    r[23:16] = v;
			2'd1:    r[15:8]  = v;
			2'd2:    r[7:0]   = v;
			default: r = rgb;
		endcase
		return r;
	endfunction

endpackage

// ===== src/pfwf_ifs.sv =====
// valid/ready channel interfaces for command words and result words
interface pfwf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [5:0] entry_index;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, cmd, entry_index, in_red, in_green, in_blue, input ready);
	modport sink (input valid, cmd, entry_index, in_red, in_green, in_blue, output ready);
endinterface

interface pfwf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [1:0] fade_state;
	logic       palette_changed;

	modport source (output valid, out_red, out_green, out_blue, fade_state, palette_changed,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, fade_state, palette_changed,
		output ready);
endinterface

// ===== src/pfwf_cell.sv =====
// one ring cell: holds a palette entry and its saved copy
module pfwf_cell
	import pfwf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t din,
	output entry_t dout
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ===== src/pfwf_head.sv =====
// transform applied to the entry passing the ring head
module pfwf_head
	import pfwf_pkg::*;
(
	input  entry_t    din,
	input  head_ctl_t ctl,
	output entry_t    dout
);

	logic [7:0] cur_c;
	logic [7:0] sav_c;

	assign cur_c = get_chan(din.pal, ctl.chan);
	assign sav_c = get_chan(din.saved, ctl.chan);

	always_comb begin
		dout = din;
		case (ctl.op)
			OP_FADE_OUT: begin
				if (cur_c < WHITE_LEVEL)
					dout.pal = set_chan(din.pal, ctl.chan, cur_c + FADE_STEP);
			end
			OP_FADE_IN: begin
				dout.pal = set_chan(din.pal, ctl.chan, (sav_c < ctl.mask) ? ctl.mask : sav_c);
			end
			OP_WHITEN: begin
				dout.saved = din.pal;
				dout.pal   = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
			end
			OP_WRITE: begin
				if (ctl.hit)
					dout.pal = ctl.wdata;
			end
			default: dout = din;
		endcase
	end

endmodule

// ===== src/palette_white_fade_sequencer.sv =====
// top level: fade sequencer control, ring of palette cells and result register
//
// The palette lives in a ring of PALETTE_ENTRIES cells, each holding one entry and its
// saved copy. Every command word that touches the palette (fade ticks that apply a step,
// save and whiten, write, read) rotates the ring one full lap: one entry passes the
// head cell per cycle, gets transformed there and re-enters at the tail, so such a word
// passes through a full ring rotation and then the result load before the next word is
// taken. Words that only change the fade mode or counters (start commands, idle ticks,
// channel advance ticks, unused codes) skip the rotation and go straight to the result
// load. One command word is in flight at a time; a new word is taken while the
// previous result word still waits at the output. Every command word gives exactly one
// result word: the addressed colour for a read (zero otherwise), the fade mode after the
// word, and a flag set when a fade-in tick rewrote the palette.
module palette_white_fade_sequencer
	import pfwf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	pfwf_in_if.sink         req,
	pfwf_out_if.source      rsp
);

	// fade state
	logic [1:0] mode_q;
	logic [3:0] tick_q;
	logic [1:0] step_q;
	logic [7:0] floor_q;

	// current word
	state_t      state_q, state_d;
	op_t         op_q;
	logic [1:0]  chan_q;
	logic [7:0]  mask_q;
	logic [5:0]  idx_q;
	logic [23:0] wdata_q;
	logic        changed_q;
	logic [23:0] rd_q;
	logic [IDX_W-1:0] lap_q;

	// result register
	logic        out_valid_q;
	logic [23:0] out_rgb_q;
	logic [1:0]  out_mode_q;
	logic        out_changed_q;

	// decoded next fade state for the offered word
	logic [1:0] dec_mode;
	logic [3:0] dec_tick;
	logic [1:0] dec_step;
	logic [7:0] dec_floor;
	op_t        dec_op;
	logic       dec_changed;

	logic accept, shift_en, load_out, out_free, lap_last, hit;
	head_ctl_t head_ctl;
	entry_t    cell_dout [PALETTE_ENTRIES];
	entry_t    head_dout;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign lap_last = (lap_q == IDX_W'(PALETTE_ENTRIES - 1));
	// entries past the store never match, so out-of-range writes and reads fall out
	assign hit      = (HIT_W'(idx_q) == HIT_W'(lap_q));

	// command decode, mirrors one step of the fade sequencer
	always_comb begin
		dec_mode    = mode_q;
		dec_tick    = tick_q;
		dec_step    = step_q;
		dec_floor   = floor_q;
		dec_op      = OP_NONE;
		dec_changed = 1'b0;
		case (cmd_t'(req.cmd))
			CMD_TICK: begin
				if (mode_q == MODE_IN || mode_q == MODE_OUT) begin
					if (step_q >= CHANNEL_COUNT) begin
						dec_mode = MODE_IDLE;
					end else if (tick_q != 4'd0) begin
						dec_tick = tick_q - 4'd1;
						if (mode_q == MODE_OUT) begin
							dec_op = OP_FADE_OUT;
						end else begin
							dec_op      = OP_FADE_IN;
							dec_floor   = floor_q - FADE_STEP;
							dec_changed = 1'b1;
						end
					end else begin
						// idle tick between channels
						dec_tick = TICKS_PER_CHANNEL;
						dec_step = step_q + 2'd1;
						if (mode_q == MODE_IN)
							dec_floor = WHITE_LEVEL;
					end
				end
			end
			CMD_FADE_OUT: begin
				dec_mode = MODE_OUT;
				dec_tick = TICKS_PER_CHANNEL;
				dec_step = 2'd0;
			end
			CMD_WHITEN: dec_op = OP_WHITEN;
			CMD_FADE_IN: begin
				dec_mode  = MODE_IN;
				dec_tick  = TICKS_PER_CHANNEL;
				dec_step  = 2'd0;
				dec_floor = WHITE_LEVEL;
			end
			CMD_WRITE: dec_op = OP_WRITE;
			CMD_READ:  dec_op = OP_READ;
			default:   dec_op = OP_NONE;
		endcase
	end

	// sequencer: one lap of the ring per palette word
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		shift_en  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_d = (dec_op == OP_NONE) ? ST_DONE : ST_SWEEP;
			end
			ST_SWEEP: begin
				shift_en = 1'b1;
				if (lap_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			tick_q    <= 4'd0;
			step_q    <= 2'd0;
			floor_q   <= 8'd0;
			op_q      <= OP_NONE;
			changed_q <= 1'b0;
			lap_q     <= '0;
		end else begin
			if (accept) begin
				mode_q    <= dec_mode;
				tick_q    <= dec_tick;
				step_q    <= dec_step;
				floor_q   <= dec_floor;
				op_q      <= dec_op;
				changed_q <= dec_changed;
			end
			if (shift_en)
				lap_q <= lap_last ? '0 : lap_q + IDX_W'(1);
		end
	end

	// word payload, taken at acceptance; the step uses the pre-update channel and mask
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q  <= step_q;
			mask_q  <= floor_q;
			idx_q   <= req.entry_index;
			wdata_q <= {req.in_red, req.in_green, req.in_blue};
			rd_q    <= 24'd0;
		end else if (shift_en && op_q == OP_READ && hit) begin
			rd_q <= cell_dout[0].pal;
		end
	end

	assign head_ctl = '{op: op_q, chan: chan_q, mask: mask_q, hit: hit, wdata: wdata_q};

	pfwf_head u_head (
		.din  (cell_dout[0]),
		.ctl  (head_ctl),
		.dout (head_dout)
	);

	// ring: each cell takes its right neighbor, the tail takes the transformed head
	for (genvar gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_ring
		entry_t cell_din;
		if (gi == PALETTE_ENTRIES - 1) begin : g_tail
			assign cell_din = head_dout;
		end else begin : g_body
			assign cell_din = cell_dout[gi + 1];
		end
		pfwf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.din      (cell_din),
			.dout     (cell_dout[gi])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rgb_q     <= rd_q;
			out_mode_q    <= mode_q;
			out_changed_q <= changed_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.out_red         = out_rgb_q[23:16];
	assign rsp.out_green       = out_rgb_q[15:8];
	assign rsp.out_blue        = out_rgb_q[7:0];
	assign rsp.fade_state      = out_mode_q;
	assign rsp.palette_changed = out_changed_q;

	// a lap always ends in the result state
	a_lap_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && lap_last) |=> (state_q == ST_DONE))
		else $error("ring lap did not hand over to result");

	// ring sits at home position outside a lap
	a_lap_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (lap_q == '0))
		else $error("ring rotated outside a lap");

	// only a fade-in tick flags a palette change
	a_changed_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.palette_changed) |-> (rsp.fade_state == MODE_IN))
		else $error("palette change flagged outside fade-in");

	// mask moves in whole fade steps
	a_floor_step: assert property (@(posedge clk) disable iff (!arst_n)
		(floor_q[4:0] == 5'd0))
		else $error("floor mask off step grid");

	// no new word taken while a lap runs
	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !req.ready)
		else $error("word taken during a lap");

endmodule

// ===== tb/sv/pfwf_checker.sv =====
`timescale 1ns / 1ps
// checker: mirrors the fade sequencer state and compares every result word
module pfwf_checker
	import pfwf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pfwf_in_if   req,
	pfwf_out_if  rsp,
	output int   fail_count,
	output int   awaited_count
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] mode;
		logic       changed;
	} result_word_t;

	logic [23:0] pal_model [PALETTE_ENTRIES];
	logic [23:0] saved_model [PALETTE_ENTRIES];
	logic [1:0]  mode_q;
	logic [3:0]  ticks_q;
	logic [1:0]  chan_q;
	logic [7:0]  mask_q;
	result_word_t awaited_results [$];
	int          word_num;

	task automatic report(input string msg);
		$display("[%0t] word %0d: %s", $time, word_num, msg);
		fail_count++;
	endtask

	task automatic apply_command(input logic [2:0] code, input logic [5:0] idx,
			input logic [23:0] color, output result_word_t res);
		int sh;
		logic [7:0] c;
		res = '0;
		case (code)
			CMD_TICK: begin
				if (mode_q == MODE_IN || mode_q == MODE_OUT) begin
					if (chan_q >= CHANNEL_COUNT) begin
						mode_q = MODE_IDLE;
					end else if (ticks_q != 4'd0) begin
						ticks_q = ticks_q - 4'd1;
						sh = 16 - 8 * int'(chan_q);
						for (int i = 0; i < PALETTE_ENTRIES; i++) begin
							if (mode_q == MODE_OUT) begin
								c = pal_model[i][sh +: 8];
								if (c < WHITE_LEVEL) begin
									pal_model[i][sh +: 8] = c + FADE_STEP;
								end
							end else begin
								c = saved_model[i][sh +: 8];
								pal_model[i][sh +: 8] = (c < mask_q) ? mask_q : c;
							end
						end
						if (mode_q == MODE_IN) begin
							mask_q = mask_q - FADE_STEP;
							res.changed = 1'b1;
						end
					end else begin
						// idle tick between channels
						ticks_q = TICKS_PER_CHANNEL;
						chan_q = chan_q + 2'd1;
						if (mode_q == MODE_IN) begin
							mask_q = WHITE_LEVEL;
						end
					end
				end
			end
			CMD_FADE_OUT: begin
				mode_q = MODE_OUT;
				ticks_q = TICKS_PER_CHANNEL;
				chan_q = 2'd0;
			end
			CMD_WHITEN: begin
				for (int i = 0; i < PALETTE_ENTRIES; i++) begin
					saved_model[i] = pal_model[i];
					pal_model[i] = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
				end
			end
			CMD_FADE_IN: begin
				mode_q = MODE_IN;
				ticks_q = TICKS_PER_CHANNEL;
				chan_q = 2'd0;
				mask_q = WHITE_LEVEL;
			end
			CMD_WRITE: begin
				if (int'(idx) < PALETTE_ENTRIES) begin
					pal_model[idx] = color;
				end
			end
			CMD_READ: begin
				if (int'(idx) < PALETTE_ENTRIES) begin
					{res.red, res.green, res.blue} = pal_model[idx];
				end
			end
			default: ;
		endcase
		res.mode = mode_q;
	endtask

	task automatic check_result();
		result_word_t want;
		if (awaited_results.size() == 0) begin
			report($sformatf("result word with nothing awaited: %0h %0h %0h mode %0d flag %0d",
				rsp.out_red, rsp.out_green, rsp.out_blue, rsp.fade_state,
				rsp.palette_changed));
			return;
		end
		want = awaited_results.pop_front();
		if (rsp.out_red !== want.red) begin
			report($sformatf("out_red %0h, want %0h", rsp.out_red, want.red));
		end
		if (rsp.out_green !== want.green) begin
			report($sformatf("out_green %0h, want %0h", rsp.out_green, want.green));
		end
		if (rsp.out_blue !== want.blue) begin
			report($sformatf("out_blue %0h, want %0h", rsp.out_blue, want.blue));
		end
		if (rsp.fade_state !== want.mode) begin
			report($sformatf("fade_state %0d, want %0d", rsp.fade_state, want.mode));
		end
		if (rsp.palette_changed !== want.changed) begin
			report($sformatf("palette_changed %0d, want %0d", rsp.palette_changed,
				want.changed));
		end
		word_num++;
	endtask

	always @(posedge clk or negedge arst_n) begin : model_update
		result_word_t res;
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				pal_model[i] = '0;
				saved_model[i] = '0;
			end
			mode_q = MODE_IDLE;
			ticks_q = '0;
			chan_q = '0;
			mask_q = '0;
			awaited_results.delete();
			awaited_count = 0;
			fail_count = 0;
			word_num = 0;
		end else begin
			// a result never belongs to a word taken at the same edge
			if (rsp.valid && rsp.ready) begin
				check_result();
			end
			if (req.valid && req.ready) begin
				apply_command(req.cmd, req.entry_index,
					{req.in_red, req.in_green, req.in_blue}, res);
				awaited_results.push_back(res);
			end
			awaited_count = awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus, result stalls and verdict
module tb_top;
	import pfwf_pkg::*;

	// command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	localparam int ITEM_TARGET  = 600;
	// a palette pass is one ring lap plus the result load, give it some margin
	localparam int DRAIN_CYCLES = 80;
	// three channels of eight active ticks and one advance tick, then the closing tick
	localparam int FADE_TICKS   = 28;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   awaited_count;
	int   words_sent;
	int   max_gap;
	int   max_stall;

	pfwf_in_if  req_if ();
	pfwf_out_if rsp_if ();

	palette_white_fade_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	pfwf_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_if),
		.rsp           (rsp_if),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs; far above the slowest legal run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// one command word: optional gap with valid low, then hold until taken
	// valid is left high after acceptance, so back-to-back words never drop it
	task automatic send_word(input logic [2:0] code, input logic [5:0] idx,
			input logic [23:0] color);
		int gap;
		gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.cmd         <= code;
		req_if.entry_index <= idx;
		req_if.in_red      <= color[23:16];
		req_if.in_green    <= color[15:8];
		req_if.in_blue     <= color[7:0];
		do @(posedge clk); while (!req_if.ready);
		words_sent++;
	endtask

	// drop valid and hold off until every result word has come back
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		wait (awaited_count == 0);
	endtask

	// start a fade and feed it ticks, with palette reads and writes mixed in
	// a short tick count leaves the fade broken off halfway
	task automatic fade_run(input logic [2:0] start_code, input int ticks);
		send_word(start_code, 6'($urandom), 24'($urandom));
		for (int t = 0; t < ticks; t++) begin
			send_word(CMD_TICK, 6'($urandom), 24'($urandom));
			case ($urandom_range(0, 11))
				0, 1: send_word(CMD_READ, 6'($urandom), 24'($urandom));
				2: send_word(CMD_WRITE, 6'($urandom), 24'($urandom));
				default: ;
			endcase
		end
	endtask

	// result side: random stall per word, ready held until the word is taken
	initial begin : result_sink
		int stall;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
			@(negedge clk);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	initial begin : stimulus
		int count;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.cmd         = CMD_TICK;
		req_if.entry_index = '0;
		req_if.in_red      = '0;
		req_if.in_green    = '0;
		req_if.in_blue     = '0;
		words_sent         = 0;
		max_gap            = 5;
		max_stall          = 5;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part: reset contents, field extremes, the 224 boundary
		send_word(CMD_READ, 6'd0, 24'h000000);
		send_word(CMD_WRITE, 6'd0, 24'h000000);
		send_word(CMD_WRITE, 6'd63, 24'hffffff);
		send_word(CMD_WRITE, 6'd1, 24'he0df1f);
		send_word(CMD_READ, 6'd63, 24'h000000);
		send_word(CMD_READ, 6'd1, 24'hffffff);
		// tick while idle and the unused codes must change nothing
		send_word(CMD_TICK, 6'd5, 24'h123456);
		send_word(CMD_SPARE_A, 6'd63, 24'hffffff);
		send_word(CMD_SPARE_B, 6'd1, 24'hffffff);
		// fade out with a read and a write while it runs
		send_word(CMD_FADE_OUT, 6'd0, 24'h000000);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		send_word(CMD_READ, 6'd1, 24'h000000);
		send_word(CMD_WRITE, 6'd2, 24'hc0c0c0);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		// switch to fade in without a saved copy, then save, whiten and fade in
		send_word(CMD_FADE_IN, 6'd0, 24'h000000);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		send_word(CMD_WHITEN, 6'd0, 24'h000000);
		send_word(CMD_READ, 6'd1, 24'h000000);
		send_word(CMD_FADE_IN, 6'd0, 24'h000000);
		send_word(CMD_TICK, 6'd0, 24'h000000);
		send_word(CMD_READ, 6'd2, 24'h000000);

		// sender pauses until the block has answered everything
		drain_results();

		// random part: mostly complete fades over random palettes
		while (words_sent < ITEM_TARGET) begin
			// some stretches run with no idling on either side
			max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 5;
			max_stall = ($urandom_range(0, 3) == 0) ? 0 : 5;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// fresh colors, then some read-back
					count = $urandom_range(1, 12);
					repeat (count) send_word(CMD_WRITE, 6'($urandom), 24'($urandom));
					count = $urandom_range(1, 4);
					repeat (count) send_word(CMD_READ, 6'($urandom), 24'($urandom));
				end
				3, 4: fade_run(CMD_FADE_OUT, FADE_TICKS + $urandom_range(0, 2));
				5, 6: begin
					// usual fade in starts from a whitened palette
					if ($urandom_range(0, 3) != 0) begin
						send_word(CMD_WHITEN, 6'($urandom), 24'($urandom));
					end
					fade_run(CMD_FADE_IN, FADE_TICKS + $urandom_range(0, 2));
				end
				7: begin
					// noise: any code with any fields, spare codes included
					count = $urandom_range(1, 6);
					repeat (count) send_word(3'($urandom), 6'($urandom), 24'($urandom));
				end
				8: begin
					// fade broken off and restarted by another start command
					fade_run(($urandom_range(0, 1) == 0) ? CMD_FADE_OUT : CMD_FADE_IN,
						$urandom_range(1, 20));
				end
				default: begin
					drain_results();
					send_word(CMD_READ, 6'($urandom), 24'($urandom));
				end
			endcase
		end

		// let the last words drain, then watch for stray result words
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
